// ===== rtl/core/tach_pkg.sv =====
// Shared types and constants for the encoder period tachometer.
// Used by the divider and the top level; depends on nothing else.
package tach_pkg;

   // Request codes on req_type.
   localparam logic [1:0] REQ_CAPTURE  = 2'd0;
   localparam logic [1:0] REQ_OVERFLOW = 2'd1;
   localparam logic [1:0] REQ_UPDATE   = 2'd2;
   localparam logic [1:0] REQ_CLEAR    = 2'd3;

   // Configuration register indexes.
   localparam int CSR_INDEX_W = 8;
   localparam logic [CSR_INDEX_W-1:0] CSR_TICK_CLOCK_HZ  = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PULSES_PER_REV = 8'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_UM_PER_PULSE   = 8'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_TIMEOUT_MS     = 8'd3;
   localparam int CSR_DATA_W = 32;

   // Datapath widths.
   localparam int DIV_W     = 48;
   localparam int DIV_CNT_W = $clog2(DIV_W);
   localparam int MUL_A_W   = 32;
   localparam int MUL_B_W   = 28;

   // 60 * 256, the Q8 scale for revolutions per minute.
   localparam logic [MUL_A_W-1:0] RPM_Q8_FACTOR = 32'd15360;
   localparam logic [31:0] SAT32 = 32'hFFFF_FFFF;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_DEN,
      ST_MUL_RPM,
      ST_LAUNCH_RPM,
      ST_WAIT_RPM,
      ST_MUL_SPD,
      ST_LAUNCH_SPD,
      ST_WAIT_SPD
   } tach_state_type;

   // Status returned by the divider.
   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

// ===== rtl/core/encoder_period_tachometer.sv =====
// Encoder period tachometer: per channel it measures the capture-timer period between
// encoder pulses, counts pulses and overflows, and on a speed update reports rpm in Q8,
// linear speed in um/s, the pulse total and a stopped flag. Capture, overflow and clear
// requests take effect in the cycle they are accepted and yield no response. A speed
// update holds the block: one shared 32x28 multiplier forms the three products in turn, and
// one restoring divider, one quotient bit per cycle, runs twice, each run launched and then
// collected. Its response becomes valid in the same cycle in which the next request can be
// taken. A stopped channel's response skips the multiplier and divider and is loaded
// straight from the final wait state. Either kind of update waits longer while an earlier
// response still sits in the output register.
// The block takes no request while an update is in progress. Depends on tach_pkg, tach_div.
module encoder_period_tachometer
   import tach_pkg::*;
#(
   parameter int CHANNELS = 2
)
(
   input  logic                   clock,
   input  logic                   reset,
   // Request channel.
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [1:0]             req_type,
   input  logic                   req_channel,
   input  logic [15:0]            req_capture_value,
   input  logic [31:0]            req_time_ms,
   // Response channel.
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_out_channel,
   output logic [31:0]            rsp_rpm_q8,
   output logic [31:0]            rsp_speed_um_per_s,
   output logic [31:0]            rsp_pulse_total,
   output logic                   rsp_stopped,
   // Configuration write channel.
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   // Configuration registers.
   logic [27:0] tick_clock_hz_ff;
   logic [15:0] pulses_per_rev_ff;
   logic [19:0] um_per_pulse_ff;
   logic [15:0] timeout_ms_ff;

   // Per-channel state.
   logic [15:0] last_cap_ff [CHANNELS];
   logic [15:0] ovf_ff      [CHANNELS];
   logic [31:0] period_ff   [CHANNELS];
   logic [31:0] last_ms_ff  [CHANNELS];
   logic [31:0] pulse_ff    [CHANNELS];

   // Sequencer and working registers.
   tach_state_type state_ff, state_in;
   logic           ch_ff;
   logic [31:0]    upd_period_ff;
   logic [31:0]    upd_pulses_ff;
   logic           upd_stopped_ff;
   logic [DIV_W-1:0] num_ff;
   logic [DIV_W-1:0] den_ff;
   logic [31:0]    rpm_ff;

   // Response registers.
   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_channel_ff;
   logic [31:0] rsp_rpm_ff;
   logic [31:0] rsp_speed_ff;
   logic [31:0] rsp_pulse_ff;
   logic        rsp_stopped_ff;

   logic                 accept;
   logic                 chan_ok;
   logic [CH_W-1:0]      idx;
   logic [31:0]          cap_period;
   logic [31:0]          elapsed_ms;
   logic                 now_stopped;
   logic                 div_start;
   logic                 rsp_load;
   logic                 rsp_free;
   logic [MUL_A_W-1:0]   mul_a;
   logic [MUL_B_W-1:0]   mul_b;
   logic [MUL_A_W+MUL_B_W-1:0] product;
   div_status_type       div_stat;
   logic [31:0]          div_quotient;

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign accept    = req_valid && req_ready;
   assign chan_ok   = (32'(req_channel) < CHANNELS);
   assign idx       = CH_W'(req_channel);
   assign rsp_free  = !rsp_valid_ff || rsp_ready;

   // Period of a capture, extended by the counted overflows.
   always_comb begin
      if (ovf_ff[idx] == 16'd0) begin
         cap_period = {16'd0, req_capture_value - last_cap_ff[idx]};
      end else begin
         cap_period = {ovf_ff[idx], 16'd0} + {16'd0, req_capture_value}
                      - {16'd0, last_cap_ff[idx]};
      end
   end

   // Stopped when the last capture is too old or no period exists.
   always_comb begin
      elapsed_ms  = req_time_ms - last_ms_ff[idx];
      now_stopped = (elapsed_ms > {16'd0, timeout_ms_ff}) || (period_ff[idx] == 32'd0);
   end

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         tick_clock_hz_ff  <= 28'd1000000;
         pulses_per_rev_ff <= 16'd20;
         um_per_pulse_ff   <= 20'd1000;
         timeout_ms_ff     <= 16'd500;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_TICK_CLOCK_HZ:  tick_clock_hz_ff  <= csr_wdata[27:0];
            CSR_PULSES_PER_REV: pulses_per_rev_ff <= csr_wdata[15:0];
            CSR_UM_PER_PULSE:   um_per_pulse_ff   <= csr_wdata[19:0];
            CSR_TIMEOUT_MS:     timeout_ms_ff     <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   // Channel state: captures, overflows and pulse count clears.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            last_cap_ff[i] <= '0;
            ovf_ff[i]      <= '0;
            period_ff[i]   <= '0;
            last_ms_ff[i]  <= '0;
            pulse_ff[i]    <= '0;
         end
      end else if (accept) begin
         if (req_type == REQ_CLEAR) begin
            for (int i = 0; i < CHANNELS; i++) begin
               pulse_ff[i] <= '0;
            end
         end else if (chan_ok && req_type == REQ_CAPTURE) begin
            period_ff[idx]   <= cap_period;
            last_cap_ff[idx] <= req_capture_value;
            ovf_ff[idx]      <= '0;
            last_ms_ff[idx]  <= req_time_ms;
            pulse_ff[idx]    <= pulse_ff[idx] + 32'd1;
         end else if (chan_ok && req_type == REQ_OVERFLOW) begin
            if (ovf_ff[idx] != 16'hFFFF) begin
               ovf_ff[idx] <= ovf_ff[idx] + 16'd1;
            end
         end
      end
   end

   // Sequencer: next state, multiplier operands, divider launch, response load.
   always_comb begin
      state_in  = state_ff;
      div_start = 1'b0;
      rsp_load  = 1'b0;
      mul_a     = '0;
      mul_b     = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept && chan_ok && req_type == REQ_UPDATE) begin
               state_in = now_stopped ? ST_WAIT_SPD : ST_MUL_DEN;
            end
         end
         ST_MUL_DEN: begin
            mul_a    = upd_period_ff;
            mul_b    = MUL_B_W'(pulses_per_rev_ff);
            state_in = ST_MUL_RPM;
         end
         ST_MUL_RPM: begin
            mul_a    = RPM_Q8_FACTOR;
            mul_b    = tick_clock_hz_ff;
            state_in = ST_LAUNCH_RPM;
         end
         ST_LAUNCH_RPM: begin
            div_start = 1'b1;
            state_in  = ST_WAIT_RPM;
         end
         ST_WAIT_RPM: begin
            if (div_stat.done) begin
               state_in = ST_MUL_SPD;
            end
         end
         ST_MUL_SPD: begin
            mul_a    = MUL_A_W'(um_per_pulse_ff);
            mul_b    = tick_clock_hz_ff;
            state_in = ST_LAUNCH_SPD;
         end
         ST_LAUNCH_SPD: begin
            div_start = 1'b1;
            state_in  = ST_WAIT_SPD;
         end
         ST_WAIT_SPD: begin
            // A stopped channel comes here directly and waits only for the output slot.
            // The quotient holds once the divider is idle, so the slot may free up later.
            if ((upd_stopped_ff || !div_stat.busy) && rsp_free) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign product = mul_a * mul_b;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Working registers of one update.
   always_ff @(posedge clock) begin
      if (accept) begin
         ch_ff          <= req_channel;
         upd_period_ff  <= period_ff[idx];
         upd_pulses_ff  <= pulse_ff[idx];
         upd_stopped_ff <= now_stopped;
      end
      case (state_ff)
         ST_MUL_DEN: den_ff <= product[DIV_W-1:0];
         ST_MUL_RPM: num_ff <= product[DIV_W-1:0];
         ST_MUL_SPD: begin
            num_ff <= product[DIV_W-1:0];
            den_ff <= {{(DIV_W-32){1'b0}}, upd_period_ff};
         end
         ST_WAIT_RPM: begin
            if (div_stat.done) begin
               rpm_ff <= div_quotient;
            end
         end
         default: ;
      endcase
   end

   tach_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .num      (num_ff),
      .den      (den_ff),
      .status   (div_stat),
      .quotient (div_quotient)
   );

   // Response register; a waiting response holds the next update, and with it new requests, in the final wait state.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_channel_ff <= ch_ff;
         rsp_rpm_ff     <= upd_stopped_ff ? 32'd0 : rpm_ff;
         rsp_speed_ff   <= upd_stopped_ff ? 32'd0 : div_quotient;
         rsp_pulse_ff   <= upd_pulses_ff;
         rsp_stopped_ff <= upd_stopped_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_out_channel    = rsp_channel_ff;
   assign rsp_rpm_q8         = rsp_rpm_ff;
   assign rsp_speed_um_per_s = rsp_speed_ff;
   assign rsp_pulse_total    = rsp_pulse_ff;
   assign rsp_stopped        = rsp_stopped_ff;

`ifndef SYNTHESIS
   // The divider finishes only while the sequencer waits for it.
   a_div_done_waited: assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> (state_ff == ST_WAIT_RPM || state_ff == ST_WAIT_SPD))
      else $error("divider finished outside a wait state");

   // A launch always starts the divider.
   a_div_launch: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LAUNCH_RPM || state_ff == ST_LAUNCH_SPD) |=> div_stat.busy)
      else $error("divider did not start after launch");

   // An accepted update keeps the block busy in the next cycle.
   a_update_busy: assert property (@(posedge clock) disable iff (reset)
      (accept && chan_ok && req_type == REQ_UPDATE) |=> !req_ready)
      else $error("update request did not occupy the sequencer");

   // A stopped channel reports zero speeds.
   a_stopped_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stopped) |-> (rsp_rpm_q8 == 32'd0 && rsp_speed_um_per_s == 32'd0))
      else $error("stopped response carries a nonzero speed");
`endif

endmodule

// ===== rtl/core/tach_div.sv =====
// Restoring divider, one quotient bit per cycle, with 32-bit saturation.
// Depends on tach_pkg.
module tach_div
   import tach_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DIV_W-1:0] num,
   input  logic [DIV_W-1:0] den,
   output div_status_type   status,
   output logic [31:0]      quotient
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_W-1:0]     rem_ff, rem_in;
   logic [DIV_W-1:0]     quo_ff, quo_in;
   logic [DIV_W-1:0]     den_ff, den_in;
   logic [DIV_W:0]       trial;
   logic [DIV_W:0]       diff;
   logic                 fits;

   // One shift, compare and subtract step.
   always_comb begin
      trial = {rem_ff, quo_ff[DIV_W-1]};
      diff  = trial - {1'b0, den_ff};
      fits  = (trial >= {1'b0, den_ff});
   end

   // Load on start, then step until every quotient bit is known.
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = num;
         den_in  = den;
      end else if (busy_ff) begin
         rem_in = fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
         quo_in = {quo_ff[DIV_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DIV_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   // A quotient above 32 bits saturates; a zero divisor yields all ones here too.
   assign quotient    = (|quo_ff[DIV_W-1:32]) ? SAT32 : quo_ff[31:0];
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

// ===== tb/tb_encoder_period_tachometer.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for encoder_period_tachometer: a directed table, then random
// encoder traffic under several register settings, checked against a local speed predictor.
// Depends on tach_pkg and the encoder_period_tachometer RTL.
module tb_encoder_period_tachometer;
   import tach_pkg::*;

   localparam int CHAN_COUNT         = 2;
   localparam int CYCLE_LIMIT        = 1_000_000;
   localparam int SETTLE_CYCLES      = 16;
   localparam int TAIL_CYCLES        = 130;
   localparam int PHASE_REQUESTS     = 180;
   localparam int DIRECTED_ROWS      = 21;

   // One speed report as the block returns it.
   typedef struct packed {
      logic        channel;
      logic [31:0] rpm_q8;
      logic [31:0] speed;
      logic [31:0] pulses;
      logic        stopped;
   } speed_report_type;

   // One row of the directed table; pinned rows carry a hand-written report.
   typedef struct packed {
      logic [1:0]       kind;
      logic             ch;
      logic [15:0]      capture;
      logic [31:0]      stamp;
      logic             pinned;
      speed_report_type want;
   } stim_row_type;

   localparam speed_report_type NO_REPORT = '0;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   logic [1:0]             req_type;
   logic                   req_channel;
   logic [15:0]            req_capture_value;
   logic [31:0]            req_time_ms;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic                   rsp_out_channel;
   logic [31:0]            rsp_rpm_q8;
   logic [31:0]            rsp_speed_um_per_s;
   logic [31:0]            rsp_pulse_total;
   logic                   rsp_stopped;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   // Hand-written report that travels with the request being offered.
   logic             pin_flag;
   speed_report_type pin_report;

   // Predictor copy of the registers and of the per-channel state.
   logic [27:0] cfg_tick_hz;
   logic [15:0] cfg_ppr;
   logic [19:0] cfg_um;
   logic [15:0] cfg_timeout;
   logic [15:0] last_cap     [CHAN_COUNT];
   logic [15:0] ovf_count    [CHAN_COUNT];
   logic [31:0] pred_period  [CHAN_COUNT];
   logic [31:0] last_ms      [CHAN_COUNT];
   logic [31:0] pred_pulses  [CHAN_COUNT];
   speed_report_type pending_reports [$];

   // Stimulus shaping and bookkeeping.
   stim_row_type directed_rows [DIRECTED_ROWS];
   logic [15:0] sent_cap [CHAN_COUNT];
   logic [31:0] scene_ms;
   logic        send_calm = 1'b0;
   logic        rsp_calm = 1'b0;
   int unsigned hold_left = 0;
   int unsigned cycle_count = 0;
   int unsigned fail_count = 0;
   int unsigned checked_reports = 0;
   int unsigned requests_sent = 0;
   int unsigned settings_applied = 1;
   int unsigned kind_count [4];

   encoder_period_tachometer #(.CHANNELS(CHAN_COUNT)) dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_type           (req_type),
      .req_channel        (req_channel),
      .req_capture_value  (req_capture_value),
      .req_time_ms        (req_time_ms),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_out_channel    (rsp_out_channel),
      .rsp_rpm_q8         (rsp_rpm_q8),
      .rsp_speed_um_per_s (rsp_speed_um_per_s),
      .rsp_pulse_total    (rsp_pulse_total),
      .rsp_stopped        (rsp_stopped),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Quotient clipped to 32 bits; a zero divisor clips as well.
   function automatic logic [31:0] clipped_quotient(input logic [63:0] num,
                                                     input logic [63:0] den);
      logic [63:0] q;
      if (den == 64'd0) return SAT32;
      q = num / den;
      return (q > {32'h0, SAT32}) ? SAT32 : q[31:0];
   endfunction

   // Applies one request to the predictor state; returns 1 when it yields a report.
   function automatic logic step_tachometer(input logic [1:0] kind, input logic ch,
                                            input logic [15:0] cap, input logic [31:0] stamp,
                                            output speed_report_type report);
      logic [31:0] elapsed;
      logic [63:0] rpm_num;
      logic [63:0] rpm_den;
      logic [63:0] spd_num;
      logic        idle;
      report = NO_REPORT;
      case (kind)
         REQ_CLEAR: begin
            for (int i = 0; i < CHAN_COUNT; i++) pred_pulses[i] = 32'd0;
            return 1'b0;
         end
         REQ_CAPTURE: begin
            // Without overflows the period wraps at 16 bits, otherwise at 32 bits.
            if (ovf_count[ch] == 16'd0)
               pred_period[ch] = {16'h0, cap - last_cap[ch]};
            else
               pred_period[ch] = {ovf_count[ch], 16'h0} + {16'h0, cap} - {16'h0, last_cap[ch]};
            last_cap[ch]    = cap;
            ovf_count[ch]   = 16'd0;
            last_ms[ch]     = stamp;
            pred_pulses[ch] = pred_pulses[ch] + 32'd1;
            return 1'b0;
         end
         REQ_OVERFLOW: begin
            if (ovf_count[ch] != 16'hFFFF) ovf_count[ch] = ovf_count[ch] + 16'd1;
            return 1'b0;
         end
         default: begin
            elapsed = stamp - last_ms[ch];
            idle    = (elapsed > {16'h0, cfg_timeout}) || (pred_period[ch] == 32'd0);
            rpm_num = {32'h0, RPM_Q8_FACTOR} * {36'h0, cfg_tick_hz};
            rpm_den = {32'h0, pred_period[ch]} * {48'h0, cfg_ppr};
            spd_num = {44'h0, cfg_um} * {36'h0, cfg_tick_hz};
            report.channel = ch;
            report.pulses  = pred_pulses[ch];
            report.stopped = idle;
            if (!idle) begin
               report.rpm_q8 = clipped_quotient(rpm_num, rpm_den);
               report.speed  = clipped_quotient(spd_num, {32'h0, pred_period[ch]});
            end
            return 1'b1;
         end
      endcase
   endfunction

   // Idle length for either side: mostly short, now and then long.
   function automatic int unsigned pause_len();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(1, 3);
      if (r < 95) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   task automatic compare_field(input string what, input logic [31:0] want,
                                input logic [31:0] seen);
      if (want !== seen) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, seen);
         fail_count++;
      end
   endtask

   // Watches all three handshakes, predicts, checks and stalls the response side.
   always @(posedge clock) begin : monitor
      speed_report_type predicted;
      speed_report_type wanted;
      cycle_count++;
      if (reset) begin
         cfg_tick_hz = 28'd1000000;
         cfg_ppr     = 16'd20;
         cfg_um      = 20'd1000;
         cfg_timeout = 16'd500;
         for (int i = 0; i < CHAN_COUNT; i++) begin
            last_cap[i]     = '0;
            ovf_count[i]    = '0;
            pred_period[i]  = '0;
            last_ms[i]      = '0;
            pred_pulses[i]  = '0;
         end
         for (int k = 0; k < 4; k++) kind_count[k] = 0;
         pending_reports.delete();
      end else begin
         // Compare a delivered report with the oldest one outstanding.
         if (rsp_valid && rsp_ready) begin
            if (pending_reports.size() == 0) begin
               $display("%0t: report for channel %0d arrived with no update request pending",
                        $time, rsp_out_channel);
               fail_count++;
            end else begin
               wanted = pending_reports.pop_front();
               compare_field("channel", {31'h0, wanted.channel}, {31'h0, rsp_out_channel});
               compare_field("rpm_q8", wanted.rpm_q8, rsp_rpm_q8);
               compare_field("speed_um_per_s", wanted.speed, rsp_speed_um_per_s);
               compare_field("pulse_total", wanted.pulses, rsp_pulse_total);
               compare_field("stopped", {31'h0, wanted.stopped}, {31'h0, rsp_stopped});
               checked_reports++;
            end
         end

         // Register writes land in the predictor copy, masked to their widths.
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_TICK_CLOCK_HZ:  cfg_tick_hz = csr_wdata[27:0];
               CSR_PULSES_PER_REV: cfg_ppr     = csr_wdata[15:0];
               CSR_UM_PER_PULSE:   cfg_um      = csr_wdata[19:0];
               CSR_TIMEOUT_MS:     cfg_timeout = csr_wdata[15:0];
               default: ;
            endcase
         end

         // Every accepted request moves the predictor; updates queue a report.
         if (req_valid && req_ready) begin
            kind_count[req_type]++;
            if (step_tachometer(req_type, req_channel, req_capture_value, req_time_ms,
                                predicted))
               pending_reports.push_back(pin_flag ? pin_report : predicted);
         end

         // Random back-pressure on the response side.
         if (hold_left != 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_ready <= 1'b1;
            if (!rsp_calm && $urandom_range(0, 7) == 0) hold_left = pause_len();
         end
      end
   end

   // Offers one request and holds it until accepted, then maybe idles.
   task automatic push_request(input logic [1:0] kind, input logic ch, input logic [15:0] cap,
                               input logic [31:0] stamp, input logic pin,
                               input speed_report_type want);
      int unsigned gap;
      req_valid         <= 1'b1;
      req_type          <= kind;
      req_channel       <= ch;
      req_capture_value <= cap;
      req_time_ms       <= stamp;
      pin_flag          <= pin;
      pin_report        <= want;
      do @(posedge clock); while (!req_ready);
      requests_sent++;
      gap = send_calm ? 0 : (($urandom_range(0, 1) == 0) ? 0 : pause_len());
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Stops sending and waits until every outstanding report has been delivered.
   task automatic drain_reports(input int unsigned tail);
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (tail) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx, input logic [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic write_settings(input logic [27:0] hz, input logic [15:0] ppr,
                                 input logic [19:0] um, input logic [15:0] tmo);
      write_csr(CSR_TICK_CLOCK_HZ, {4'h0, hz});
      write_csr(CSR_PULSES_PER_REV, {16'h0, ppr});
      write_csr(CSR_UM_PER_PULSE, {12'h0, um});
      write_csr(CSR_TIMEOUT_MS, {16'h0, tmo});
      csr_valid <= 1'b0;
      settings_applied++;
   endtask

   // Advances the scene clock: often not at all, sometimes past the timeout, rarely a jump.
   task automatic next_stamp();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 35) return;
      if (r < 80) scene_ms = scene_ms + $urandom_range(1, 40);
      else if (r < 93) scene_ms = scene_ms + $urandom_range(100, 1000);
      else if (r < 98) scene_ms = scene_ms + $urandom_range(1000, 70000);
      else scene_ms = $urandom;
   endtask

   // A realistic pulse: now and then up to three timer overflows, a capture, then up to two speed updates.
   task automatic wheel_turn();
      logic        ch;
      logic [31:0] noise;
      logic [15:0] cap;
      int unsigned laps;
      int unsigned r;
      ch    = 1'($urandom_range(0, 1));
      laps  = ($urandom_range(0, 9) < 7) ? 0 : $urandom_range(1, 3);
      noise = $urandom;
      repeat (laps) push_request(REQ_OVERFLOW, ch, noise[15:0], scene_ms, 1'b0, NO_REPORT);
      r = $urandom_range(0, 99);
      if (r < 5) cap = sent_cap[ch];
      else if (r < 40) cap = sent_cap[ch] + 16'($urandom_range(1, 64));
      else if (r < 75) cap = sent_cap[ch] + 16'($urandom_range(65, 8000));
      else if (r < 85) cap = sent_cap[ch] + 16'($urandom_range(8001, 65535));
      else cap = 16'($urandom_range(0, 65535));
      sent_cap[ch] = cap;
      next_stamp();
      push_request(REQ_CAPTURE, ch, cap, scene_ms, 1'b0, NO_REPORT);
      repeat ($urandom_range(0, 2)) begin
         next_stamp();
         noise = $urandom;
         push_request(REQ_UPDATE, ($urandom_range(0, 3) == 0) ? ~ch : ch, noise[15:0],
                      scene_ms, 1'b0, NO_REPORT);
      end
   endtask

   // Any request with any field values.
   task automatic noise_item();
      logic [31:0] bits;
      logic [31:0] stamp;
      bits  = $urandom;
      stamp = ($urandom_range(0, 3) == 0) ? $urandom : scene_ms;
      push_request(bits[1:0], bits[2], bits[31:16], stamp, 1'b0, NO_REPORT);
   endtask

   // One register setting followed by a stretch of random traffic.
   task automatic run_phase(input logic [27:0] hz, input logic [15:0] ppr,
                            input logic [19:0] um, input logic [15:0] tmo);
      int unsigned stop_at;
      drain_reports(SETTLE_CYCLES);
      write_settings(hz, ppr, um, tmo);
      send_calm = ($urandom_range(0, 3) == 0);
      rsp_calm  = ($urandom_range(0, 3) == 0);
      stop_at   = requests_sent + PHASE_REQUESTS;
      while (requests_sent < stop_at) begin
         if ($urandom_range(0, 3) != 0) wheel_turn();
         else noise_item();
         // Occasionally let the block run dry in the middle of a phase.
         if ($urandom_range(0, 149) == 0) drain_reports(SETTLE_CYCLES);
      end
   endtask

   initial begin : stimulus
      reset             <= 1'b1;
      req_valid         <= 1'b0;
      req_type          <= REQ_CAPTURE;
      req_channel       <= 1'b0;
      req_capture_value <= 16'h0;
      req_time_ms       <= 32'h0;
      csr_valid         <= 1'b0;
      csr_index         <= CSR_TICK_CLOCK_HZ;
      csr_wdata         <= '0;
      pin_flag          <= 1'b0;
      pin_report        <= NO_REPORT;
      sent_cap[0] = 16'h0;
      sent_cap[1] = 16'h0;
      scene_ms    = 32'd20;

      // Directed table under the reset settings (1 MHz ticks, 20 ppr, 1000 um, 500 ms).
      // Both channels start stopped because no period has been measured.
      directed_rows[0]  = '{REQ_UPDATE, 1'b0, 16'h0000, 32'h0000_0000, 1'b1,
                            '{1'b0, 32'd0, 32'd0, 32'd0, 1'b1}};
      directed_rows[1]  = '{REQ_UPDATE, 1'b1, 16'hFFFF, 32'hFFFF_FFFF, 1'b1,
                            '{1'b1, 32'd0, 32'd0, 32'd0, 1'b1}};
      // A 1000-tick period: 768000 in Q8 (3000 rpm) and 1 m/s.
      directed_rows[2]  = '{REQ_CAPTURE, 1'b0, 16'd1000, 32'd100, 1'b0, NO_REPORT};
      directed_rows[3]  = '{REQ_UPDATE, 1'b0, 16'h0000, 32'd100, 1'b1,
                            '{1'b0, 32'd768000, 32'd1000000, 32'd1, 1'b0}};
      // One millisecond past the timeout, then exactly at it.
      directed_rows[4]  = '{REQ_UPDATE, 1'b0, 16'h0000, 32'd601, 1'b1,
                            '{1'b0, 32'd0, 32'd0, 32'd1, 1'b1}};
      directed_rows[5]  = '{REQ_UPDATE, 1'b0, 16'h0000, 32'd600, 1'b0, NO_REPORT};
      // Capture below the last one wraps at 16 bits.
      directed_rows[6]  = '{REQ_CAPTURE, 1'b0, 16'd999, 32'd700, 1'b0, NO_REPORT};
      directed_rows[7]  = '{REQ_UPDATE, 1'b0, 16'h0000, 32'd700, 1'b0, NO_REPORT};
      // Two overflows stretch the period past 16 bits.
      directed_rows[8]  = '{REQ_OVERFLOW, 1'b1, 16'hA5A5, 32'd700, 1'b0, NO_REPORT};
      directed_rows[9]  = '{REQ_OVERFLOW, 1'b1, 16'h5A5A, 32'd700, 1'b0, NO_REPORT};
      directed_rows[10] = '{REQ_CAPTURE, 1'b1, 16'hFFFF, 32'd5, 1'b0, NO_REPORT};
      directed_rows[11] = '{REQ_UPDATE, 1'b1, 16'h0000, 32'd5, 1'b0, NO_REPORT};
      // Same capture again without overflow gives a zero period, hence stopped.
      directed_rows[12] = '{REQ_CAPTURE, 1'b1, 16'hFFFF, 32'd10, 1'b0, NO_REPORT};
      directed_rows[13] = '{REQ_UPDATE, 1'b1, 16'h0000, 32'd10, 1'b1,
                            '{1'b1, 32'd0, 32'd0, 32'd2, 1'b0 | 1'b1}};
      // One-tick period across the millisecond wrap.
      directed_rows[14] = '{REQ_CAPTURE, 1'b0, 16'd1000, 32'hFFFF_FFF0, 1'b0, NO_REPORT};
      directed_rows[15] = '{REQ_UPDATE, 1'b0, 16'h0000, 32'h0000_0010, 1'b1,
                            '{1'b0, 32'd768000000, 32'd1000000000, 32'd3, 1'b0}};
      // Clearing the counts touches both channels but not the periods.
      directed_rows[16] = '{REQ_CLEAR, 1'b1, 16'hFFFF, 32'hFFFF_FFFF, 1'b0, NO_REPORT};
      directed_rows[17] = '{REQ_UPDATE, 1'b0, 16'h0000, 32'd10, 1'b0, NO_REPORT};
      directed_rows[18] = '{REQ_UPDATE, 1'b1, 16'h0000, 32'd10, 1'b1,
                            '{1'b1, 32'd0, 32'd0, 32'd0, 1'b1}};
      directed_rows[19] = '{REQ_CAPTURE, 1'b1, 16'h0000, 32'd0, 1'b0, NO_REPORT};
      directed_rows[20] = '{REQ_UPDATE, 1'b1, 16'h0000, 32'd0, 1'b0, NO_REPORT};

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int row = 0; row < DIRECTED_ROWS; row++)
         push_request(directed_rows[row].kind, directed_rows[row].ch,
                      directed_rows[row].capture, directed_rows[row].stamp,
                      directed_rows[row].pinned, directed_rows[row].want);

      // Move the right channel to a known capture before the random phases.
      push_request(REQ_CAPTURE, 1'b1, 16'h1234, 32'd20, 1'b0, NO_REPORT);
      push_request(REQ_UPDATE, 1'b1, 16'h0000, 32'd20, 1'b0, NO_REPORT);
      sent_cap[0] = 16'd1000;
      sent_cap[1] = 16'h1234;

      // Upper extremes (saturating speeds), lower extremes, zero pulses per revolution,
      // then random settings.
      run_phase(28'd170000000, 16'd1, 20'd1000000, 16'd65535);
      run_phase(28'd1, 16'd65535, 20'd0, 16'd0);
      run_phase(28'($urandom_range(1, 170000000)), 16'd0, 20'($urandom_range(0, 1000000)),
                16'($urandom_range(0, 1000)));
      repeat (3)
         run_phase(28'($urandom_range(1, 170000000)), 16'($urandom_range(1, 65535)),
                   20'($urandom_range(0, 1000000)),
                   16'(($urandom_range(0, 1) == 0) ? $urandom_range(0, 1000)
                                                   : $urandom_range(0, 65535)));

      drain_reports(TAIL_CYCLES);

      $display("Run covered %0d captures, %0d overflows, %0d speed updates and %0d clears",
               kind_count[REQ_CAPTURE], kind_count[REQ_OVERFLOW], kind_count[REQ_UPDATE],
               kind_count[REQ_CLEAR]);
      $display("over %0d register settings; %0d reports compared, %0d mismatches.",
               settings_applied, checked_reports, fail_count);
      if (fail_count == 0 && pending_reports.size() == 0)
         $display("tb_encoder_period_tachometer: PASS");
      else
         $display("tb_encoder_period_tachometer: FAIL");
      $finish;
   end

   // Hang guard.
   initial begin : watchdog
      wait (cycle_count >= CYCLE_LIMIT);
      $display("%0t: cycle limit reached with %0d reports outstanding", $time,
               pending_reports.size());
      $display("tb_encoder_period_tachometer: FAIL");
      $finish;
   end

endmodule
